[rtl/tbc_pkg.sv]
package tbc_pkg;

  // Fixed field widths of the ports.
  localparam int PIX_W      = 8;
  localparam int COORD_W    = 12;
  localparam int ERR_W      = 13;
  localparam int SIZE_W     = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 3;

  // Default frame size bounds for the top level parameters.
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  // Pixel levels and register reset values.
  localparam logic [PIX_W-1:0]   WHITE_LEVEL     = 8'd255;
  localparam logic [PIX_W-1:0]   BLACK_LEVEL     = 8'd0;
  localparam logic [SIZE_W-1:0]  RST_FRAME_SIZE  = 13'd1944;
  localparam logic [PIX_W-1:0]   RST_THRESHOLD   = 8'd20;
  localparam logic [COORD_W-1:0] RST_TARGET      = 12'd0;
  localparam logic [SIZE_W-1:0]  RST_LIMIT       = 13'd1944;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_THRESHOLD    = 3'd2,
    REG_TARGET_X     = 3'd3,
    REG_TARGET_Y     = 3'd4,
    REG_LIMIT_X      = 3'd5,
    REG_LIMIT_Y      = 3'd6
  } reg_idx_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [SIZE_W-1:0]  frame_width;
    logic [SIZE_W-1:0]  frame_height;
    logic [PIX_W-1:0]   threshold;
    logic [COORD_W-1:0] target_x;
    logic [COORD_W-1:0] target_y;
    logic [SIZE_W-1:0]  limit_x;
    logic [SIZE_W-1:0]  limit_y;
  } cfg_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_RUN,
    ST_START_X,
    ST_WAIT_X,
    ST_START_Y,
    ST_WAIT_Y,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic pix_accept;
    logic div_start;
    logic div_sel_y;
    logic cap_x;
    logic cap_y;
    logic load_frame;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic frame_end;
    logic frame_empty;
    logic div_busy;
  } dp_status_t;

endpackage

[rtl/tbc_div.sv]
module tbc_div import tbc_pkg::*; #(
  parameter int QW = 12,
  parameter int NW = 25
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [QW+NW-1:0] dividend,
  input  logic [NW-1:0]    divisor,
  output logic             busy,
  output logic [QW-1:0]    quotient
);

  localparam int CNT_W = $clog2(QW + 1);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0]    rem_r, rem_nxt;
  logic [QW-1:0]    lo_r, lo_nxt;
  logic [NW-1:0]    div_r, div_nxt;
  logic [NW:0]      trial;
  logic             ge;

  // One restoring step per cycle; the quotient bits shift into the low word.
  // The upper dividend bits start below the divisor since the mean fits in QW bits.
  always_comb begin
    trial    = {rem_r, lo_r[QW-1]};
    ge       = (trial >= {1'b0, div_r});
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(QW);
      rem_nxt  = dividend[QW+NW-1:QW];
      lo_nxt   = dividend[QW-1:0];
      div_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? NW'(trial - {1'b0, div_r}) : NW'(trial);
      lo_nxt  = QW'({lo_r, ge});
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Operand and result words carry no reset.
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    div_r <= div_nxt;
  end

  assign busy     = busy_r;
  assign quotient = lo_r;

endmodule

[rtl/tbc_ctrl.sv]
module tbc_ctrl import tbc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  dp_status_t status,
  output logic       in_stall,
  output dp_cmd_t    cmd
);

  state_t state_r, state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_RUN: begin
        in_stall = !status.out_free;
        if (in_valid && status.out_free) begin
          cmd.pix_accept = 1'b1;
          if (status.frame_end) begin
            state_nxt = status.frame_empty ? ST_FINISH : ST_START_X;
          end
        end
      end
      ST_START_X: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_WAIT_X;
      end
      ST_WAIT_X: begin
        if (!status.div_busy) begin
          cmd.cap_x = 1'b1;
          state_nxt = ST_START_Y;
        end
      end
      ST_START_Y: begin
        cmd.div_start = 1'b1;
        cmd.div_sel_y = 1'b1;
        state_nxt     = ST_WAIT_Y;
      end
      ST_WAIT_Y: begin
        if (!status.div_busy) begin
          cmd.cap_y = 1'b1;
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.load_frame = 1'b1;
          state_nxt      = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/tbc_datapath.sv]
module tbc_datapath import tbc_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cfg_t                     cfg,
  input  dp_cmd_t                  cmd,
  output dp_status_t               status,
  input  logic [PIX_W-1:0]         in_pixel,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [PIX_W-1:0]         out_binary_pixel,
  output logic                     out_frame_done,
  output logic                     out_found,
  output logic [COORD_W-1:0]       out_centroid_x,
  output logic [COORD_W-1:0]       out_centroid_y,
  output logic signed [ERR_W-1:0]  out_error_x,
  output logic signed [ERR_W-1:0]  out_error_y,
  output logic                     out_in_bounds
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int NW  = CW + RW + 1;
  localparam int SXW = 2 * CW + RW;
  localparam int SYW = CW + 2 * RW;
  localparam int QW  = (CW > RW) ? CW : RW;
  localparam int DW  = QW + NW;

  logic [CW-1:0]  col_r, col_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic [SXW-1:0] sum_x_r, sum_x_nxt, sum_x_add;
  logic [SYW-1:0] sum_y_r, sum_y_nxt, sum_y_add;
  logic [NW-1:0]  cnt_r, cnt_nxt, cnt_add;

  logic [SXW-1:0] snap_sx_r;
  logic [SYW-1:0] snap_sy_r;
  logic [NW-1:0]  snap_n_r;
  logic           white_last_r;
  logic [COORD_W-1:0] qx_r, qy_r;

  logic [31:0]    fw32, fh32, w32, h32;
  logic [WW-1:0]  w;
  logic [HW-1:0]  h;
  logic           white, row_end, frame_end;

  logic [DW-1:0]  div_dividend;
  logic           div_busy;
  logic [QW-1:0]  div_quot;

  logic           found;
  logic [COORD_W-1:0] cx, cy;
  logic [ERR_W-1:0]   ex, ey;
  logic           inb;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_free;
  logic [PIX_W-1:0]     o_bin_r;
  logic                 o_done_r, o_found_r, o_inb_r;
  logic [COORD_W-1:0]   o_cx_r, o_cy_r;
  logic [ERR_W-1:0]     o_ex_r, o_ey_r;

  // Frame size clamped into one to the maximum.
  always_comb begin
    fw32 = 32'(cfg.frame_width);
    fh32 = 32'(cfg.frame_height);
    if (fw32 == 32'd0) begin
      w32 = 32'd1;
    end else if (fw32 > 32'(MAX_WIDTH)) begin
      w32 = 32'(MAX_WIDTH);
    end else begin
      w32 = fw32;
    end
    if (fh32 == 32'd0) begin
      h32 = 32'd1;
    end else if (fh32 > 32'(MAX_HEIGHT)) begin
      h32 = 32'(MAX_HEIGHT);
    end else begin
      h32 = fh32;
    end
    w = WW'(w32);
    h = HW'(h32);
  end

  // Threshold and raster position of the current pixel.
  assign white     = (in_pixel > cfg.threshold);
  assign row_end   = (WW'(col_r) >= (w - WW'(1)));
  assign frame_end = row_end && (HW'(row_r) >= (h - HW'(1)));

  // Accumulators with the current pixel added.
  assign sum_x_add = white ? (sum_x_r + SXW'(col_r)) : sum_x_r;
  assign sum_y_add = white ? (sum_y_r + SYW'(row_r)) : sum_y_r;
  assign cnt_add   = white ? (cnt_r + NW'(1)) : cnt_r;

  // Counter and accumulator update on each accepted pixel.
  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    sum_x_nxt = sum_x_r;
    sum_y_nxt = sum_y_r;
    cnt_nxt   = cnt_r;
    if (cmd.pix_accept) begin
      if (frame_end) begin
        col_nxt   = '0;
        row_nxt   = '0;
        sum_x_nxt = '0;
        sum_y_nxt = '0;
        cnt_nxt   = '0;
      end else begin
        sum_x_nxt = sum_x_add;
        sum_y_nxt = sum_y_add;
        cnt_nxt   = cnt_add;
        if (row_end) begin
          col_nxt = '0;
          row_nxt = row_r + RW'(1);
        end else begin
          col_nxt = col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      sum_x_r <= '0;
      sum_y_r <= '0;
      cnt_r   <= '0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      sum_x_r <= sum_x_nxt;
      sum_y_r <= sum_y_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Frame totals are held for the divider while the accumulators restart.
  always_ff @(posedge clk) begin
    if (cmd.pix_accept && frame_end) begin
      snap_sx_r    <= sum_x_add;
      snap_sy_r    <= sum_y_add;
      snap_n_r     <= cnt_add;
      white_last_r <= white;
    end
    if (cmd.cap_x) begin
      qx_r <= COORD_W'(div_quot);
    end
    if (cmd.cap_y) begin
      qy_r <= COORD_W'(div_quot);
    end
  end

  // One divider serves both coordinates in turn.
  assign div_dividend = cmd.div_sel_y ? DW'(snap_sy_r) : DW'(snap_sx_r);

  tbc_div #(
    .QW (QW),
    .NW (NW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (snap_n_r),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  // Frame result from the captured quotients.
  always_comb begin
    found = (snap_n_r != '0);
    cx    = found ? qx_r : '0;
    cy    = found ? qy_r : '0;
    ex    = found ? (ERR_W'(qx_r) - ERR_W'(cfg.target_x)) : '0;
    ey    = found ? (ERR_W'(qy_r) - ERR_W'(cfg.target_y)) : '0;
    inb   = found && (qx_r != '0) && (SIZE_W'(qx_r) < cfg.limit_x)
                  && (qy_r != '0) && (SIZE_W'(qy_r) < cfg.limit_y);
  end

  // Output register: free when empty or when its item is taken this cycle.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if ((cmd.pix_accept && !frame_end) || cmd.load_frame) begin
      out_valid_nxt = 1'b1;
    end else if (out_free) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pix_accept && !frame_end) begin
      o_bin_r   <= white ? WHITE_LEVEL : BLACK_LEVEL;
      o_done_r  <= 1'b0;
      o_found_r <= 1'b0;
      o_cx_r    <= '0;
      o_cy_r    <= '0;
      o_ex_r    <= '0;
      o_ey_r    <= '0;
      o_inb_r   <= 1'b0;
    end else if (cmd.load_frame) begin
      o_bin_r   <= white_last_r ? WHITE_LEVEL : BLACK_LEVEL;
      o_done_r  <= 1'b1;
      o_found_r <= found;
      o_cx_r    <= cx;
      o_cy_r    <= cy;
      o_ex_r    <= ex;
      o_ey_r    <= ey;
      o_inb_r   <= inb;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_binary_pixel = o_bin_r;
  assign out_frame_done   = o_done_r;
  assign out_found        = o_found_r;
  assign out_centroid_x   = o_cx_r;
  assign out_centroid_y   = o_cy_r;
  assign out_error_x      = $signed(o_ex_r);
  assign out_error_y      = $signed(o_ey_r);
  assign out_in_bounds    = o_inb_r;

  // Status for the controller.
  assign status.out_free    = out_free;
  assign status.frame_end   = frame_end;
  assign status.frame_empty = (cnt_r == '0) && !white;
  assign status.div_busy    = div_busy;

endmodule

[rtl/threshold_blob_centroid_unit.sv]
// An ordinary pixel gives its item in the cycle after it is accepted. The last pixel
// of a frame gives the frame item after the shared restoring divider has run Q steps
// for each coordinate, Q being the quotient width, X first and then Y, and once the
// output register is free. An empty frame skips the divider for the finish state.
// Throughput: one pixel per cycle while the output is free; a frame end holds the input.
// Reset (rst_n low, synchronous) restores the register defaults and clears all counters.
module threshold_blob_centroid_unit import tbc_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [PIX_W-1:0]         in_pixel,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [PIX_W-1:0]         out_binary_pixel,
  output logic                     out_frame_done,
  output logic                     out_found,
  output logic [COORD_W-1:0]       out_centroid_x,
  output logic [COORD_W-1:0]       out_centroid_y,
  output logic signed [ERR_W-1:0]  out_error_x,
  output logic signed [ERR_W-1:0]  out_error_y,
  output logic                     out_in_bounds,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  cfg_t       cfg_r, cfg_nxt;
  dp_cmd_t    cmd;
  dp_status_t status;

  // Configuration register writes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_FRAME_WIDTH:  cfg_nxt.frame_width  = cfg_data[SIZE_W-1:0];
        REG_FRAME_HEIGHT: cfg_nxt.frame_height = cfg_data[SIZE_W-1:0];
        REG_THRESHOLD:    cfg_nxt.threshold    = cfg_data[PIX_W-1:0];
        REG_TARGET_X:     cfg_nxt.target_x     = cfg_data[COORD_W-1:0];
        REG_TARGET_Y:     cfg_nxt.target_y     = cfg_data[COORD_W-1:0];
        REG_LIMIT_X:      cfg_nxt.limit_x      = cfg_data[SIZE_W-1:0];
        REG_LIMIT_Y:      cfg_nxt.limit_y      = cfg_data[SIZE_W-1:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= RST_FRAME_SIZE;
      cfg_r.frame_height <= RST_FRAME_SIZE;
      cfg_r.threshold    <= RST_THRESHOLD;
      cfg_r.target_x     <= RST_TARGET;
      cfg_r.target_y     <= RST_TARGET;
      cfg_r.limit_x      <= RST_LIMIT;
      cfg_r.limit_y      <= RST_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Controller.
  tbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // Datapath.
  tbc_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .cmd              (cmd),
    .status           (status),
    .in_pixel         (in_pixel),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_binary_pixel (out_binary_pixel),
    .out_frame_done   (out_frame_done),
    .out_found        (out_found),
    .out_centroid_x   (out_centroid_x),
    .out_centroid_y   (out_centroid_y),
    .out_error_x      (out_error_x),
    .out_error_y      (out_error_y),
    .out_in_bounds    (out_in_bounds)
  );

endmodule

[sim/centroid_checker.sv]
`timescale 1ns / 100ps
module centroid_checker import tbc_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [PIX_W-1:0]         in_pixel,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [PIX_W-1:0]         out_binary_pixel,
  input  logic                     out_frame_done,
  input  logic                     out_found,
  input  logic [COORD_W-1:0]       out_centroid_x,
  input  logic [COORD_W-1:0]       out_centroid_y,
  input  logic signed [ERR_W-1:0]  out_error_x,
  input  logic signed [ERR_W-1:0]  out_error_y,
  input  logic                     out_in_bounds,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  output int unsigned              fail_count,
  output int unsigned              pending
);

  typedef struct packed {
    logic [PIX_W-1:0]   binary_pixel;
    logic               frame_done;
    logic               found;
    logic [COORD_W-1:0] centroid_x;
    logic [COORD_W-1:0] centroid_y;
    logic [ERR_W-1:0]   error_x;
    logic [ERR_W-1:0]   error_y;
    logic               in_bounds;
  } pixel_result_t;

  // Shadow copy of the register file.
  cfg_t regs;

  // Raster position and white pixel accumulators of the current frame.
  logic [11:0] col_cnt;
  logic [11:0] row_cnt;
  logic [35:0] col_sum;
  logic [35:0] row_sum;
  logic [24:0] white_cnt;

  // Predicted result items, oldest first.
  pixel_result_t expected_q[$];

  pixel_result_t seen;
  pixel_result_t want;
  int unsigned   eff_w;
  int unsigned   eff_h;
  logic          row_end;
  logic          frame_end;
  logic [35:0]   quot_x;
  logic [35:0]   quot_y;

  function automatic string describe(pixel_result_t r);
    return $sformatf("bin=%0d done=%0b found=%0b cx=%0d cy=%0d ex=%0d ey=%0d inb=%0b",
                     r.binary_pixel, r.frame_done, r.found, r.centroid_x, r.centroid_y,
                     $signed(r.error_x), $signed(r.error_y), r.in_bounds);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      regs.frame_width  = RST_FRAME_SIZE;
      regs.frame_height = RST_FRAME_SIZE;
      regs.threshold    = RST_THRESHOLD;
      regs.target_x     = RST_TARGET;
      regs.target_y     = RST_TARGET;
      regs.limit_x      = RST_LIMIT;
      regs.limit_y      = RST_LIMIT;
      col_cnt           = '0;
      row_cnt           = '0;
      col_sum           = '0;
      row_sum           = '0;
      white_cnt         = '0;
      expected_q.delete();
    end else begin
      // Compare the item leaving the block with the oldest prediction.
      if (out_valid && !out_stall) begin
        seen = {out_binary_pixel, out_frame_done, out_found, out_centroid_x,
                out_centroid_y, out_error_x, out_error_y, out_in_bounds};
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected result item at %0t ns: %s", $time, describe(seen));
          end
        end else begin
          want = expected_q.pop_front();
          if (seen !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("result item mismatch at %0t ns", $time);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(seen));
            end
          end
        end
      end

      // Track register writes; the spare index is ignored.
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_FRAME_WIDTH:  regs.frame_width  = cfg_data[SIZE_W-1:0];
          REG_FRAME_HEIGHT: regs.frame_height = cfg_data[SIZE_W-1:0];
          REG_THRESHOLD:    regs.threshold    = cfg_data[PIX_W-1:0];
          REG_TARGET_X:     regs.target_x     = cfg_data[COORD_W-1:0];
          REG_TARGET_Y:     regs.target_y     = cfg_data[COORD_W-1:0];
          REG_LIMIT_X:      regs.limit_x      = cfg_data[SIZE_W-1:0];
          REG_LIMIT_Y:      regs.limit_y      = cfg_data[SIZE_W-1:0];
          default: ;
        endcase
      end

      // Threshold the accepted pixel and advance the raster position.
      if (in_valid && !in_stall) begin
        eff_w = (regs.frame_width == 0) ? 1 :
                (regs.frame_width > MAX_WIDTH) ? MAX_WIDTH : regs.frame_width;
        eff_h = (regs.frame_height == 0) ? 1 :
                (regs.frame_height > MAX_HEIGHT) ? MAX_HEIGHT : regs.frame_height;
        row_end   = col_cnt >= eff_w - 1;
        frame_end = row_end && (row_cnt >= eff_h - 1);
        want = '0;
        if (in_pixel > regs.threshold) begin
          want.binary_pixel = WHITE_LEVEL;
          col_sum   = col_sum + col_cnt;
          row_sum   = row_sum + row_cnt;
          white_cnt = white_cnt + 1'b1;
        end else begin
          want.binary_pixel = BLACK_LEVEL;
        end
        want.frame_done = frame_end;

        // On the last pixel report the floored centroid, then start a new frame.
        if (frame_end) begin
          if (white_cnt != 0) begin
            quot_x = col_sum / white_cnt;
            quot_y = row_sum / white_cnt;
            want.found      = 1'b1;
            want.centroid_x = quot_x[COORD_W-1:0];
            want.centroid_y = quot_y[COORD_W-1:0];
            want.error_x    = {1'b0, want.centroid_x} - {1'b0, regs.target_x};
            want.error_y    = {1'b0, want.centroid_y} - {1'b0, regs.target_y};
            want.in_bounds  = (want.centroid_x != 0) &&
                              ({1'b0, want.centroid_x} < regs.limit_x) &&
                              (want.centroid_y != 0) &&
                              ({1'b0, want.centroid_y} < regs.limit_y);
          end
          col_sum   = '0;
          row_sum   = '0;
          white_cnt = '0;
          col_cnt   = '0;
          row_cnt   = '0;
        end else if (row_end) begin
          col_cnt = '0;
          row_cnt = row_cnt + 1'b1;
        end else begin
          col_cnt = col_cnt + 1'b1;
        end
        expected_q.push_back(want);
      end
    end
    pending = expected_q.size();
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
module tb_top import tbc_pkg::*; ();

  localparam int RUN_LIMIT    = 2_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 500;
  localparam int CALM_TAIL    = 200;
  localparam int CLAMP_ITEMS  = 300;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef enum int {MIX_UNIFORM, MIX_SPARSE, MIX_EDGE, MIX_BRIGHT} pixel_mix_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [PIX_W-1:0]         in_pixel;
  logic                     out_valid;
  logic                     out_stall;
  logic [PIX_W-1:0]         out_binary_pixel;
  logic                     out_frame_done;
  logic                     out_found;
  logic [COORD_W-1:0]       out_centroid_x;
  logic [COORD_W-1:0]       out_centroid_y;
  logic signed [ERR_W-1:0]  out_error_x;
  logic signed [ERR_W-1:0]  out_error_y;
  logic                     out_in_bounds;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_cnt;
  bit          quiet;
  bit          hold_go;
  logic [PIX_W-1:0] pix_list[$];

  threshold_blob_centroid_unit u_top (.*);

  centroid_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel         (in_pixel),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_binary_pixel (out_binary_pixel),
    .out_frame_done   (out_frame_done),
    .out_found        (out_found),
    .out_centroid_x   (out_centroid_x),
    .out_centroid_y   (out_centroid_y),
    .out_error_x      (out_error_x),
    .out_error_y      (out_error_y),
    .out_in_bounds    (out_in_bounds),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offer one pixel, possibly after an idle burst, and wait until it is taken.
  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= pix;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_list();
    foreach (pix_list[i]) send_pixel(pix_list[i]);
    in_valid <= 1'b0;
  endtask

  task automatic send_random(input int count);
    repeat (count) send_pixel(PIX_W'($urandom));
    in_valid <= 1'b0;
  endtask

  // Wait until every predicted item has come out, then realign to the rising edge.
  task automatic drain_results();
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Write all registers back to back, then poke the unused index.
  task automatic load_config(input logic [SIZE_W-1:0] fw, input logic [SIZE_W-1:0] fh,
                             input logic [PIX_W-1:0] thr, input logic [COORD_W-1:0] tx,
                             input logic [COORD_W-1:0] ty, input logic [SIZE_W-1:0] lx,
                             input logic [SIZE_W-1:0] ly);
    logic [CFG_DATA_W-1:0] vals [8];
    logic [CFG_IDX_W-1:0]  idxs [8];
    vals = '{fw, fh, {5'($urandom), thr}, {1'($urandom), tx}, {1'($urandom), ty},
             lx, ly, CFG_DATA_W'($urandom)};
    idxs = '{REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_THRESHOLD, REG_TARGET_X,
             REG_TARGET_Y, REG_LIMIT_X, REG_LIMIT_Y, REG_SPARE};
    cfg_we <= 1'b1;
    for (int i = 0; i < 8; i++) begin
      cfg_index <= idxs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Result side stall: random bursts, plus one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && rst_n && $urandom_range(0, 11) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Run time limit.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < RUN_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    int               sent;
    int               phase;
    int               count;
    int               thr_i;
    logic [SIZE_W-1:0]  cw;
    logic [SIZE_W-1:0]  ch;
    logic [SIZE_W-1:0]  clx;
    logic [SIZE_W-1:0]  cly;
    logic [PIX_W-1:0]   cthr;
    logic [PIX_W-1:0]   pix;
    logic [COORD_W-1:0] ctx;
    logic [COORD_W-1:0] cty;
    pixel_mix_t         mix;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_pixel  = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    quiet     = 1'b0;
    hold_go   = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: pixels at and just above the threshold, mid-row stop.
    pix_list = '{8'd20, 8'd21, 8'd255, 8'd0, 8'd7};
    send_list();

    // Shrink the frame mid-row, finish it, then an empty frame.
    drain_results();
    load_config(13'd3, 13'd2, 8'd100, 12'd0, 12'd0, 13'd8191, 13'd8191);
    pix_list = '{8'd0, 8'd255, 8'd101, 8'd100, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
    send_list();

    // Zero sizes act as one: every pixel is a frame at the origin.
    drain_results();
    load_config(13'd0, 13'd0, 8'd0, 12'd4095, 12'd4095, 13'd1, 13'd1);
    pix_list = '{8'd0, 8'd1, 8'd255};
    send_list();

    // Single white pixel inside the limits, then a full frame floored to zero.
    drain_results();
    load_config(13'd2, 13'd2, 8'd254, 12'd0, 12'd0, 13'd2, 13'd2);
    pix_list = '{8'd0, 8'd254, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
    send_list();

    // Oversized width clamps to the maximum row; the row stays open.
    drain_results();
    load_config(13'd8191, 13'd1, 8'd128, 12'd0, 12'd4095, 13'd4096, 13'd8191);
    send_random(CLAMP_ITEMS);

    // One pixel per row, oversized height clamps to the maximum.
    drain_results();
    load_config(13'd1, 13'd8191, 8'd200, 12'd4095, 12'd0, 13'd8191, 13'd4096);
    send_random(CLAMP_ITEMS);

    // Full width partly filled; the next setting shrinks it mid-row.
    drain_results();
    load_config(13'd4096, 13'd0, 8'd20, 12'd2048, 12'd2048, 13'd0, 13'd0);
    send_random(50);

    // Random phases with small frames; the tail runs without idling.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_results();
      quiet = (sent >= RANDOM_ITEMS - CALM_TAIL) || ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 3))
        0:       cw = 13'd0;
        1:       cw = 13'd1;
        2:       cw = SIZE_W'($urandom_range(1, 6));
        default: cw = SIZE_W'($urandom_range(1, 40));
      endcase
      case ($urandom_range(0, 3))
        0:       ch = 13'd0;
        1:       ch = 13'd1;
        2:       ch = SIZE_W'($urandom_range(1, 6));
        default: ch = SIZE_W'($urandom_range(1, 12));
      endcase
      case ($urandom_range(0, 5))
        0:       cthr = 8'd0;
        1:       cthr = 8'd255;
        default: cthr = PIX_W'($urandom_range(1, 254));
      endcase
      case ($urandom_range(0, 3))
        0:       ctx = 12'd0;
        1:       ctx = 12'd4095;
        2:       ctx = COORD_W'($urandom_range(0, 40));
        default: ctx = COORD_W'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0:       cty = 12'd0;
        1:       cty = 12'd4095;
        2:       cty = COORD_W'($urandom_range(0, 12));
        default: cty = COORD_W'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0:       clx = 13'd0;
        1:       clx = 13'd1;
        2:       clx = 13'd8191;
        3:       clx = SIZE_W'($urandom);
        default: clx = SIZE_W'($urandom_range(0, 45));
      endcase
      case ($urandom_range(0, 4))
        0:       cly = 13'd0;
        1:       cly = 13'd1;
        2:       cly = 13'd8191;
        3:       cly = SIZE_W'($urandom);
        default: cly = SIZE_W'($urandom_range(0, 15));
      endcase
      load_config(cw, ch, cthr, ctx, cty, clx, cly);

      count = $urandom_range(20, 120);
      // One phase holds the result side off so the block backs up.
      if (phase == 3) begin
        hold_go = 1'b1;
        count   = 200;
      end
      mix   = pixel_mix_t'($urandom_range(0, 3));
      thr_i = cthr;
      repeat (count) begin
        case (mix)
          MIX_UNIFORM: pix = PIX_W'($urandom);
          MIX_SPARSE:  pix = ($urandom_range(0, 9) == 0) ? PIX_W'($urandom_range(thr_i, 255)) :
                                                           PIX_W'($urandom_range(0, thr_i));
          MIX_EDGE:    pix = PIX_W'($urandom_range((thr_i == 0) ? 0 : thr_i - 1,
                                                   (thr_i == 255) ? 255 : thr_i + 1));
          default:     pix = WHITE_LEVEL;
        endcase
        send_pixel(pix);
      end
      in_valid <= 1'b0;
      sent  += count;
      phase += 1;
    end

    // Let the last frame end settle, then give the verdict.
    drain_results();
    repeat (64) @(negedge clk);
    if (pending != 0) begin
      $display("%0d result items never arrived", pending);
    end
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
